// ===== rtl/drt_pkg.sv =====
// Shared types, constants and helper functions of the damage rectangle tracker.
package drt_pkg;

   localparam int DEF_MAX_RECTS = 12;
   localparam int GROW_MARGIN   = 8;
   localparam int CANVAS_LIMIT  = 4096;

   localparam int RECT_W    = 16;
   localparam int POS_W     = 12;
   localparam int DIM_W     = 13;
   localparam int AREA_W    = 2 * DIM_W;
   localparam int OUTCOME_W = 3;
   localparam int SLOT_W    = 4;
   localparam int CSR_IDX_W = 1;

   localparam logic [DIM_W-1:0] CANVAS_WIDTH_RESET  = 13'd1920;
   localparam logic [DIM_W-1:0] CANVAS_HEIGHT_RESET = 13'd1080;

   localparam logic [CSR_IDX_W-1:0] CSR_CANVAS_WIDTH  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CANVAS_HEIGHT = 1'd1;

   localparam logic [OUTCOME_W-1:0] OUTCOME_DROPPED    = 3'd0;
   localparam logic [OUTCOME_W-1:0] OUTCOME_MERGED     = 3'd1;
   localparam logic [OUTCOME_W-1:0] OUTCOME_APPENDED   = 3'd2;
   localparam logic [OUTCOME_W-1:0] OUTCOME_FOLDED     = 3'd3;
   localparam logic [OUTCOME_W-1:0] OUTCOME_LISTED     = 3'd4;
   localparam logic [OUTCOME_W-1:0] OUTCOME_LIST_EMPTY = 3'd5;

   typedef struct packed {
      logic [POS_W-1:0] x;
      logic [POS_W-1:0] y;
      logic [DIM_W-1:0] w;
      logic [DIM_W-1:0] h;
   } box_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_DROP,
      ST_EMPTY,
      ST_NEAR_RD,
      ST_NEAR_CHK,
      ST_MERGE,
      ST_APPEND,
      ST_FOLD_RD,
      ST_FOLD_BOX,
      ST_FOLD_MUL_U,
      ST_FOLD_MUL_E,
      ST_FOLD_CMP,
      ST_FOLD_WR,
      ST_DRAIN_RD,
      ST_DRAIN_OUT
   } state_type;

   // Bounding box of two rectangles that both lie inside the canvas.
   function automatic box_type box_union(box_type a, box_type b);
      logic [DIM_W-1:0] a_x1;
      logic [DIM_W-1:0] b_x1;
      logic [DIM_W-1:0] a_y1;
      logic [DIM_W-1:0] b_y1;
      logic [DIM_W-1:0] x1;
      logic [DIM_W-1:0] y1;
      box_type          r;
      a_x1 = {1'b0, a.x} + a.w;
      b_x1 = {1'b0, b.x} + b.w;
      a_y1 = {1'b0, a.y} + a.h;
      b_y1 = {1'b0, b.y} + b.h;
      x1   = (a_x1 > b_x1) ? a_x1 : b_x1;
      y1   = (a_y1 > b_y1) ? a_y1 : b_y1;
      r.x  = (a.x < b.x) ? a.x : b.x;
      r.y  = (a.y < b.y) ? a.y : b.y;
      r.w  = x1 - {1'b0, r.x};
      r.h  = y1 - {1'b0, r.y};
      return r;
   endfunction

endpackage

// ===== rtl/drt_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
module drt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/damage_rect_tracker.sv =====
// Top level of the damage rectangle tracker: sequencer, clipping and list walker.
//
//   Channel  Direction  Word
//   req_     in         action, rect_x, rect_y, rect_w, rect_h
//   rsp_     out        outcome, slot, out_x, out_y, out_w, out_h, last
//   csr_     in         canvas_width (index 0), canvas_height (index 1)
//
// A drop or an empty drain answers straight after decode; a mark walks the list
// until an entry lies near it (merge) or the list ends (append, or a fold into a
// full list: read, union, two area products, compare for each entry); a drain
// emits each entry. One list RAM read port and one shared multiplier set this.
// Reset clears the list count and loads the canvas registers; no clearing pass.
// A stalled result holds the sequencer only where it must emit the next word.
module damage_rect_tracker #(
   parameter int MAX_RECTS = drt_pkg::DEF_MAX_RECTS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_action,
   input  logic signed [drt_pkg::RECT_W-1:0]   req_rect_x,
   input  logic signed [drt_pkg::RECT_W-1:0]   req_rect_y,
   input  logic signed [drt_pkg::RECT_W-1:0]   req_rect_w,
   input  logic signed [drt_pkg::RECT_W-1:0]   req_rect_h,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [drt_pkg::OUTCOME_W-1:0]       rsp_outcome,
   output logic [drt_pkg::SLOT_W-1:0]          rsp_slot,
   output logic [drt_pkg::POS_W-1:0]           rsp_out_x,
   output logic [drt_pkg::POS_W-1:0]           rsp_out_y,
   output logic [drt_pkg::DIM_W-1:0]           rsp_out_w,
   output logic [drt_pkg::DIM_W-1:0]           rsp_out_h,
   output logic                                rsp_last,
   input  logic                                csr_wr_en,
   input  logic [drt_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [drt_pkg::DIM_W-1:0]           csr_wdata
);

   localparam int ADDR_W = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
   localparam int CNT_W  = $clog2(MAX_RECTS + 1);
   localparam int BOX_W  = $bits(drt_pkg::box_type);
   localparam int DIM_W  = drt_pkg::DIM_W;
   localparam int AREA_W = drt_pkg::AREA_W;
   localparam int RECT_W = drt_pkg::RECT_W;

   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_RECTS);
   localparam logic [CNT_W-1:0] IDX_LAST = CNT_W'(MAX_RECTS - 1);
   localparam logic [DIM_W-1:0] DIM_LIMIT = DIM_W'(drt_pkg::CANVAS_LIMIT);
   localparam logic [DIM_W:0]   MARGIN = (DIM_W + 1)'(drt_pkg::GROW_MARGIN);

   drt_pkg::state_type state_ff, state_in;

   logic [DIM_W-1:0]        canvas_w_ff, canvas_w_in;
   logic [DIM_W-1:0]        canvas_h_ff, canvas_h_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [CNT_W-1:0]        idx_ff, idx_in;
   logic                    act_ff, act_in;
   logic signed [RECT_W-1:0] rx_ff, rx_in;
   logic signed [RECT_W-1:0] ry_ff, ry_in;
   logic signed [RECT_W-1:0] rw_ff, rw_in;
   logic signed [RECT_W-1:0] rh_ff, rh_in;
   drt_pkg::box_type        t_ff, t_in;
   drt_pkg::box_type        e_ff, e_in;
   drt_pkg::box_type        u_ff, u_in;
   logic [AREA_W-1:0]       area_u_ff, area_u_in;
   logic [AREA_W-1:0]       area_e_ff, area_e_in;
   logic [AREA_W-1:0]       best_cost_ff, best_cost_in;
   logic [CNT_W-1:0]        best_idx_ff, best_idx_in;
   drt_pkg::box_type        best_box_ff, best_box_in;
   logic                    best_valid_ff, best_valid_in;

   logic                            rsp_valid_ff, rsp_valid_in;
   logic [drt_pkg::OUTCOME_W-1:0]   rsp_outcome_ff, rsp_outcome_in;
   logic [drt_pkg::SLOT_W-1:0]      rsp_slot_ff, rsp_slot_in;
   drt_pkg::box_type                rsp_box_ff, rsp_box_in;
   logic                            rsp_last_ff, rsp_last_in;

   // List RAM.
   logic                    ram_wr_en;
   logic [ADDR_W-1:0]       ram_wr_addr;
   drt_pkg::box_type        ram_wr_data;
   drt_pkg::box_type        ram_rd_data;

   // Datapath terms.
   logic                    out_free;
   logic                    list_full;
   logic                    idx_at_count;
   logic [DIM_W-1:0]        cw;
   logic [DIM_W-1:0]        ch;
   logic signed [RECT_W:0]  x_end, y_end, x_lo, y_lo, x_hi, y_hi, cw_s, ch_s;
   logic signed [RECT_W:0]  w_diff, h_diff;
   logic                    clip_empty;
   drt_pkg::box_type        clip_box;
   logic                    near;
   logic [DIM_W:0]          t_x1_grown, t_y1_grown, e_x1_grown, e_y1_grown;
   logic [DIM_W-1:0]        mul_a, mul_b;
   logic [AREA_W-1:0]       mul_p;
   logic [AREA_W-1:0]       cost;

   // Word emission.
   logic                            emit;
   logic [drt_pkg::OUTCOME_W-1:0]   emit_outcome;
   logic [CNT_W-1:0]                emit_slot;
   drt_pkg::box_type                emit_box;
   logic                            emit_last;

   drt_ram #(
      .WIDTH (BOX_W),
      .DEPTH (MAX_RECTS)
   ) u_list_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (idx_ff[ADDR_W-1:0]),
      .rd_data (ram_rd_data)
   );

   assign req_ready   = (state_ff == drt_pkg::ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_outcome = rsp_outcome_ff;
   assign rsp_slot    = rsp_slot_ff;
   assign rsp_out_x   = rsp_box_ff.x;
   assign rsp_out_y   = rsp_box_ff.y;
   assign rsp_out_w   = rsp_box_ff.w;
   assign rsp_out_h   = rsp_box_ff.h;
   assign rsp_last    = rsp_last_ff;

   assign out_free     = !rsp_valid_ff || rsp_ready;
   assign list_full    = (count_ff == CNT_FULL);
   assign idx_at_count = ((idx_ff + CNT_W'(1)) == count_ff);

   always_comb begin : datapath
      cw = (canvas_w_ff > DIM_LIMIT) ? DIM_LIMIT : canvas_w_ff;
      ch = (canvas_h_ff > DIM_LIMIT) ? DIM_LIMIT : canvas_h_ff;
      cw_s = $signed({4'b0, cw});
      ch_s = $signed({4'b0, ch});

      // Clip the latched mark to the canvas.
      x_end  = $signed({rx_ff[RECT_W-1], rx_ff}) + $signed({rw_ff[RECT_W-1], rw_ff});
      y_end  = $signed({ry_ff[RECT_W-1], ry_ff}) + $signed({rh_ff[RECT_W-1], rh_ff});
      x_lo   = rx_ff[RECT_W-1] ? '0 : $signed({1'b0, rx_ff});
      y_lo   = ry_ff[RECT_W-1] ? '0 : $signed({1'b0, ry_ff});
      x_hi   = (x_end > cw_s) ? cw_s : x_end;
      y_hi   = (y_end > ch_s) ? ch_s : y_end;
      w_diff = x_hi - x_lo;
      h_diff = y_hi - y_lo;
      clip_empty = (rw_ff <= 16'sd0) || (rh_ff <= 16'sd0) ||
                   (x_hi <= x_lo) || (y_hi <= y_lo);
      clip_box.x = x_lo[drt_pkg::POS_W-1:0];
      clip_box.y = y_lo[drt_pkg::POS_W-1:0];
      clip_box.w = w_diff[DIM_W-1:0];
      clip_box.h = h_diff[DIM_W-1:0];

      // The mark and the stored box are near when, with the far edges of both grown by
      // the margin, each edge of one lies before the far edge of the other on both axes.
      t_x1_grown = {2'b0, t_ff.x} + {1'b0, t_ff.w} + MARGIN;
      t_y1_grown = {2'b0, t_ff.y} + {1'b0, t_ff.h} + MARGIN;
      e_x1_grown = {2'b0, ram_rd_data.x} + {1'b0, ram_rd_data.w} + MARGIN;
      e_y1_grown = {2'b0, ram_rd_data.y} + {1'b0, ram_rd_data.h} + MARGIN;
      near = ({2'b0, ram_rd_data.x} < t_x1_grown) && ({2'b0, t_ff.x} < e_x1_grown) &&
             ({2'b0, ram_rd_data.y} < t_y1_grown) && ({2'b0, t_ff.y} < e_y1_grown);

      // One multiplier serves both area products of a fold step.
      mul_a = (state_ff == drt_pkg::ST_FOLD_MUL_U) ? u_ff.w : e_ff.w;
      mul_b = (state_ff == drt_pkg::ST_FOLD_MUL_U) ? u_ff.h : e_ff.h;
      mul_p = AREA_W'(mul_a) * AREA_W'(mul_b);
      cost  = area_u_ff - area_e_ff;
   end

   always_comb begin : next_state
      state_in = state_ff;
      unique case (state_ff)
         drt_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = drt_pkg::ST_DECODE;
            end
         end
         drt_pkg::ST_DECODE: begin
            if (act_ff) begin
               state_in = (count_ff == '0) ? drt_pkg::ST_EMPTY : drt_pkg::ST_DRAIN_RD;
            end else if (clip_empty) begin
               state_in = drt_pkg::ST_DROP;
            end else if (count_ff == '0) begin
               state_in = drt_pkg::ST_APPEND;
            end else begin
               state_in = drt_pkg::ST_NEAR_RD;
            end
         end
         drt_pkg::ST_NEAR_RD: state_in = drt_pkg::ST_NEAR_CHK;
         drt_pkg::ST_NEAR_CHK: begin
            if (near) begin
               state_in = drt_pkg::ST_MERGE;
            end else if (idx_at_count) begin
               state_in = list_full ? drt_pkg::ST_FOLD_RD : drt_pkg::ST_APPEND;
            end else begin
               state_in = drt_pkg::ST_NEAR_RD;
            end
         end
         drt_pkg::ST_FOLD_RD:    state_in = drt_pkg::ST_FOLD_BOX;
         drt_pkg::ST_FOLD_BOX:   state_in = drt_pkg::ST_FOLD_MUL_U;
         drt_pkg::ST_FOLD_MUL_U: state_in = drt_pkg::ST_FOLD_MUL_E;
         drt_pkg::ST_FOLD_MUL_E: state_in = drt_pkg::ST_FOLD_CMP;
         drt_pkg::ST_FOLD_CMP: begin
            state_in = (idx_ff == IDX_LAST) ? drt_pkg::ST_FOLD_WR : drt_pkg::ST_FOLD_RD;
         end
         drt_pkg::ST_DRAIN_RD: state_in = drt_pkg::ST_DRAIN_OUT;
         drt_pkg::ST_DRAIN_OUT: begin
            if (out_free) begin
               state_in = idx_at_count ? drt_pkg::ST_IDLE : drt_pkg::ST_DRAIN_RD;
            end
         end
         drt_pkg::ST_DROP, drt_pkg::ST_EMPTY, drt_pkg::ST_MERGE,
         drt_pkg::ST_APPEND, drt_pkg::ST_FOLD_WR: begin
            if (out_free) begin
               state_in = drt_pkg::ST_IDLE;
            end
         end
      endcase
   end

   always_comb begin : outputs
      canvas_w_in   = canvas_w_ff;
      canvas_h_in   = canvas_h_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      act_in        = act_ff;
      rx_in         = rx_ff;
      ry_in         = ry_ff;
      rw_in         = rw_ff;
      rh_in         = rh_ff;
      t_in          = t_ff;
      e_in          = e_ff;
      u_in          = u_ff;
      area_u_in     = area_u_ff;
      area_e_in     = area_e_ff;
      best_cost_in  = best_cost_ff;
      best_idx_in   = best_idx_ff;
      best_box_in   = best_box_ff;
      best_valid_in = best_valid_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = idx_ff[ADDR_W-1:0];
      ram_wr_data   = t_ff;
      emit          = 1'b0;
      emit_outcome  = drt_pkg::OUTCOME_DROPPED;
      emit_slot     = '0;
      emit_box      = '0;
      emit_last     = 1'b1;

      if (csr_wr_en) begin
         unique case (csr_index)
            drt_pkg::CSR_CANVAS_WIDTH:  canvas_w_in = csr_wdata;
            drt_pkg::CSR_CANVAS_HEIGHT: canvas_h_in = csr_wdata;
         endcase
      end

      unique case (state_ff)
         drt_pkg::ST_IDLE: begin
            if (req_valid) begin
               act_in = req_action;
               rx_in  = req_rect_x;
               ry_in  = req_rect_y;
               rw_in  = req_rect_w;
               rh_in  = req_rect_h;
            end
         end
         drt_pkg::ST_DECODE: begin
            t_in          = clip_box;
            idx_in        = '0;
            best_valid_in = 1'b0;
         end
         drt_pkg::ST_DROP: begin
            emit = out_free;
         end
         drt_pkg::ST_EMPTY: begin
            emit         = out_free;
            emit_outcome = drt_pkg::OUTCOME_LIST_EMPTY;
         end
         drt_pkg::ST_NEAR_RD: begin
         end
         drt_pkg::ST_NEAR_CHK: begin
            if (!near) begin
               idx_in = (idx_at_count && list_full) ? '0 : idx_ff + CNT_W'(1);
            end
         end
         drt_pkg::ST_MERGE: begin
            ram_wr_data  = drt_pkg::box_union(ram_rd_data, t_ff);
            ram_wr_en    = out_free;
            emit         = out_free;
            emit_outcome = drt_pkg::OUTCOME_MERGED;
            emit_slot    = idx_ff;
            emit_box     = ram_wr_data;
         end
         drt_pkg::ST_APPEND: begin
            ram_wr_addr  = count_ff[ADDR_W-1:0];
            ram_wr_en    = out_free;
            emit         = out_free;
            emit_outcome = drt_pkg::OUTCOME_APPENDED;
            emit_slot    = count_ff;
            emit_box     = t_ff;
            if (out_free) begin
               count_in = count_ff + CNT_W'(1);
            end
         end
         drt_pkg::ST_FOLD_RD: begin
         end
         drt_pkg::ST_FOLD_BOX: begin
            e_in = ram_rd_data;
            u_in = drt_pkg::box_union(ram_rd_data, t_ff);
         end
         drt_pkg::ST_FOLD_MUL_U: begin
            area_u_in = mul_p;
         end
         drt_pkg::ST_FOLD_MUL_E: begin
            area_e_in = mul_p;
         end
         drt_pkg::ST_FOLD_CMP: begin
            // Strict compare keeps the first entry among equal costs.
            if (!best_valid_ff || (cost < best_cost_ff)) begin
               best_valid_in = 1'b1;
               best_cost_in  = cost;
               best_idx_in   = idx_ff;
               best_box_in   = u_ff;
            end
            idx_in = idx_ff + CNT_W'(1);
         end
         drt_pkg::ST_FOLD_WR: begin
            ram_wr_addr  = best_idx_ff[ADDR_W-1:0];
            ram_wr_data  = best_box_ff;
            ram_wr_en    = out_free;
            emit         = out_free;
            emit_outcome = drt_pkg::OUTCOME_FOLDED;
            emit_slot    = best_idx_ff;
            emit_box     = best_box_ff;
         end
         drt_pkg::ST_DRAIN_RD: begin
         end
         drt_pkg::ST_DRAIN_OUT: begin
            emit         = out_free;
            emit_outcome = drt_pkg::OUTCOME_LISTED;
            emit_slot    = idx_ff;
            emit_box     = ram_rd_data;
            emit_last    = idx_at_count;
            if (out_free) begin
               if (idx_at_count) begin
                  count_in = '0;
               end else begin
                  idx_in = idx_ff + CNT_W'(1);
               end
            end
         end
      endcase

      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_outcome_in = rsp_outcome_ff;
      rsp_slot_in    = rsp_slot_ff;
      rsp_box_in     = rsp_box_ff;
      rsp_last_in    = rsp_last_ff;
      if (emit) begin
         rsp_valid_in   = 1'b1;
         rsp_outcome_in = emit_outcome;
         rsp_slot_in    = drt_pkg::SLOT_W'(emit_slot);
         rsp_box_in     = emit_box;
         rsp_last_in    = emit_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= drt_pkg::ST_IDLE;
         canvas_w_ff  <= drt_pkg::CANVAS_WIDTH_RESET;
         canvas_h_ff  <= drt_pkg::CANVAS_HEIGHT_RESET;
         count_ff     <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         canvas_w_ff  <= canvas_w_in;
         canvas_h_ff  <= canvas_h_in;
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff         <= act_in;
      rx_ff          <= rx_in;
      ry_ff          <= ry_in;
      rw_ff          <= rw_in;
      rh_ff          <= rh_in;
      t_ff           <= t_in;
      e_ff           <= e_in;
      u_ff           <= u_in;
      area_u_ff      <= area_u_in;
      area_e_ff      <= area_e_in;
      best_cost_ff   <= best_cost_in;
      best_idx_ff    <= best_idx_in;
      best_box_ff    <= best_box_in;
      best_valid_ff  <= best_valid_in;
      rsp_outcome_ff <= rsp_outcome_in;
      rsp_slot_ff    <= rsp_slot_in;
      rsp_box_ff     <= rsp_box_in;
      rsp_last_ff    <= rsp_last_in;
   end

`ifndef SYNTHESIS
   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_FULL)
      else $error("list count exceeds the list depth");

   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> ({1'b0, ram_wr_addr} < (ADDR_W + 1)'(MAX_RECTS)))
      else $error("list write beyond the last entry");

   a_append_counts: assert property (@(posedge clock) disable iff (reset)
      (emit && (emit_outcome == drt_pkg::OUTCOME_APPENDED))
      |=> (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("append did not grow the list by one");

   a_fold_only_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_outcome == drt_pkg::OUTCOME_FOLDED)) |-> list_full)
      else $error("fold reported while the list has room");

   a_drain_clears: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_last && (rsp_outcome == drt_pkg::OUTCOME_LISTED))
      |-> (count_ff == '0))
      else $error("list not cleared after its last entry was read out");
`endif

endmodule
